### design/msgpack_token_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// msgpack token decoder assertion macros
// Short wrappers for the concurrent checks of the decoder core.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_TOKEN_DECODER_CORE_ASSERT_SVH
`define MSGPACK_TOKEN_DECODER_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define MTD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold at the same edge as the antecedent
`define MTD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Widths, token kinds, parse phases and lead-byte decoding of the decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int DataW   = 8;
  localparam int KindW   = 5;
  localparam int ValueW  = 64;
  localparam int HdrCntW = 4;
  localparam int PayCntW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_NIL     = 5'd0,
    KIND_FALSE   = 5'd1,
    KIND_TRUE    = 5'd2,
    KIND_INT8    = 5'd3,
    KIND_INT16   = 5'd4,
    KIND_INT32   = 5'd5,
    KIND_INT64   = 5'd6,
    KIND_UINT8   = 5'd7,
    KIND_UINT16  = 5'd8,
    KIND_UINT32  = 5'd9,
    KIND_UINT64  = 5'd10,
    KIND_FLOAT32 = 5'd11,
    KIND_FLOAT64 = 5'd12,
    KIND_STR8    = 5'd13,
    KIND_STR16   = 5'd14,
    KIND_STR32   = 5'd15,
    KIND_BIN8    = 5'd16,
    KIND_BIN16   = 5'd17,
    KIND_BIN32   = 5'd18,
    KIND_ARRAY8  = 5'd19,
    KIND_ARRAY16 = 5'd20,
    KIND_ARRAY32 = 5'd21,
    KIND_MAP8    = 5'd22,
    KIND_MAP16   = 5'd23,
    KIND_MAP32   = 5'd24,
    KIND_EOF     = 5'd25,
    KIND_ERROR   = 5'd26
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // what a lead byte asks for
  typedef struct packed {
    logic                done;   // token complete with this byte
    logic                start;  // header bytes follow
    logic                err;    // unknown lead byte
    kind_t               kind;
    logic [HdrCntW-1:0]  len;
    logic [DataW-1:0]    value;
  } lead_t;

  function automatic logic is_strbin(input kind_t kind);
    return (kind >= KIND_STR8) && (kind <= KIND_BIN32);
  endfunction

  function automatic lead_t lead_decode(input logic [DataW-1:0] b);
    lead_t l;
    l = '{done: 1'b0, start: 1'b0, err: 1'b0, kind: KIND_NIL,
          len: '0, value: '0};
    unique case (b) inside
      [8'h00:8'h7F], [8'hE0:8'hFF]: begin
        l.done  = 1'b1;
        l.kind  = KIND_INT8;
        l.value = b;
      end
      [8'h80:8'h8F]: begin
        l.done  = 1'b1;
        l.kind  = KIND_MAP8;
        l.value = {4'h0, b[3:0]};
      end
      [8'h90:8'h9F]: begin
        l.done  = 1'b1;
        l.kind  = KIND_ARRAY8;
        l.value = {4'h0, b[3:0]};
      end
      [8'hA0:8'hBF]: begin
        l.done  = 1'b1;
        l.kind  = KIND_STR8;
        l.value = {3'h0, b[4:0]};
      end
      8'hC0: begin l.done = 1'b1; l.kind = KIND_NIL;   end
      8'hC2: begin l.done = 1'b1; l.kind = KIND_FALSE; end
      8'hC3: begin l.done = 1'b1; l.kind = KIND_TRUE;  end
      8'hC4: begin l.start = 1'b1; l.kind = KIND_BIN8;    l.len = 4'd1; end
      8'hC5: begin l.start = 1'b1; l.kind = KIND_BIN16;   l.len = 4'd2; end
      8'hC6: begin l.start = 1'b1; l.kind = KIND_BIN32;   l.len = 4'd4; end
      8'hCA: begin l.start = 1'b1; l.kind = KIND_FLOAT32; l.len = 4'd4; end
      8'hCB: begin l.start = 1'b1; l.kind = KIND_FLOAT64; l.len = 4'd8; end
      8'hCC: begin l.start = 1'b1; l.kind = KIND_UINT8;   l.len = 4'd1; end
      8'hCD: begin l.start = 1'b1; l.kind = KIND_UINT16;  l.len = 4'd2; end
      8'hCE: begin l.start = 1'b1; l.kind = KIND_UINT32;  l.len = 4'd4; end
      8'hCF: begin l.start = 1'b1; l.kind = KIND_UINT64;  l.len = 4'd8; end
      8'hD0: begin l.start = 1'b1; l.kind = KIND_INT8;    l.len = 4'd1; end
      8'hD1: begin l.start = 1'b1; l.kind = KIND_INT16;   l.len = 4'd2; end
      8'hD2: begin l.start = 1'b1; l.kind = KIND_INT32;   l.len = 4'd4; end
      8'hD3: begin l.start = 1'b1; l.kind = KIND_INT64;   l.len = 4'd8; end
      8'hD9: begin l.start = 1'b1; l.kind = KIND_STR8;    l.len = 4'd1; end
      8'hDA: begin l.start = 1'b1; l.kind = KIND_STR16;   l.len = 4'd2; end
      8'hDB: begin l.start = 1'b1; l.kind = KIND_STR32;   l.len = 4'd4; end
      8'hDC: begin l.start = 1'b1; l.kind = KIND_ARRAY16; l.len = 4'd2; end
      8'hDD: begin l.start = 1'b1; l.kind = KIND_ARRAY32; l.len = 4'd4; end
      8'hDE: begin l.start = 1'b1; l.kind = KIND_MAP16;   l.len = 4'd2; end
      8'hDF: begin l.start = 1'b1; l.kind = KIND_MAP32;   l.len = 4'd4; end
      // never-used code, ext and fixext
      default: begin
        l.err  = 1'b1;
        l.kind = KIND_ERROR;
      end
    endcase
    return l;
  endfunction

endpackage

### design/mtd_in_if.sv
// ----------------------------------------------------------------------------
// mtd_in_if
// Byte channel into the decoder: one encoded byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface mtd_in_if;
  import mtd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

### design/mtd_out_if.sv
// ----------------------------------------------------------------------------
// mtd_out_if
// Token channel out of the decoder: one header, payload, eof or error result.
// ----------------------------------------------------------------------------
interface mtd_out_if;
  import mtd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KindW-1:0]  token_kind;
  logic              is_payload;
  logic [ValueW-1:0] header_value;
  logic [DataW-1:0]  payload_byte;
  logic              last_of_run;

  modport source (output valid, output token_kind, output is_payload,
                  output header_value, output payload_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input is_payload,
                  input header_value, input payload_byte, input last_of_run,
                  output ready);
endinterface

### design/msgpack_token_decoder_core.sv
// ----------------------------------------------------------------------------
// msgpack_token_decoder_core
// Byte-at-a-time MessagePack tokenizer with valid/ready channels.
// ----------------------------------------------------------------------------
// byte_in takes one encoded word per cycle while its ready is high: data_byte
// plus end_of_buffer on the last byte of a buffer. token_out gives one result
// word per cycle while its ready is high: value headers, str/bin payload bytes,
// eof and error, with last_of_run on the final result caused by a given input byte.
// A byte is registered at acceptance, decoded against the parse state while
// it sits in the input register, and its results land in the result
// register, from which token_out is driven; a byte whose results find the
// result register full waits in the input register.
// Throughput is one byte per clock while token_out is ready. A byte that
// yields two results (a token and eof) holds the result register until both
// are taken, the only case where the input register waits on a ready token_out.
// Header bytes in progress and bytes ignored after an error make no result
// and pass through without using the result register.
// While token_out is stalled one more byte is held in the input register,
// then byte_in.ready drops.
// Reset clears the parse state and the valid flags of both registers; parsing
// restarts at a lead byte. End of buffer also returns the parse state to reset.
// ----------------------------------------------------------------------------
`include "msgpack_token_decoder_core_assert.svh"

module msgpack_token_decoder_core (
  input  logic clk,
  input  logic rst,
  mtd_in_if.sink    byte_in,
  mtd_out_if.source token_out
);
  import mtd_pkg::*;

  // input register
  logic             a_valid;
  logic [DataW-1:0] a_data;
  logic             a_eob;

  // parse state
  phase_t             phase, phase_next;
  kind_t              pend_kind, pend_kind_next;
  logic [HdrCntW-1:0] hdr_left, hdr_left_next;
  logic [ValueW-1:0]  acc, acc_next;
  logic [PayCntW-1:0] pay_left, pay_left_next;
  logic               err_seen, err_seen_next;

  // result register: one token word and a pending eof
  logic              tok_valid;
  logic              eof_valid;
  kind_t             r_kind;
  logic              r_pay;
  logic [ValueW-1:0] r_value;
  logic [DataW-1:0]  r_byte;

  // decode results
  lead_t             lead;
  logic [ValueW-1:0] acc_shift;
  logic              fin;
  kind_t             fin_kind;
  logic [ValueW-1:0] fin_value;
  logic              err_now;
  logic              gen_tok;
  logic              gen_eof;
  kind_t             t_kind;
  logic              t_pay;
  logic [ValueW-1:0] t_value;
  logic [DataW-1:0]  t_byte;

  logic in_take, out_take, out_last_take, slot_free, a_advance;

  always_comb begin
    lead           = lead_decode(a_data);
    acc_shift      = {acc[ValueW-DataW-1:0], a_data};
    phase_next     = phase;
    pend_kind_next = pend_kind;
    hdr_left_next  = hdr_left;
    acc_next       = acc;
    pay_left_next  = pay_left;
    err_seen_next  = err_seen;
    fin            = 1'b0;
    fin_kind       = KIND_NIL;
    fin_value      = '0;
    err_now        = 1'b0;
    gen_tok        = 1'b0;
    gen_eof        = 1'b0;
    t_kind         = KIND_NIL;
    t_pay          = 1'b0;
    t_value        = '0;
    t_byte         = '0;

    if (!err_seen) begin
      unique case (phase)
        PH_HEADER: begin
          acc_next      = acc_shift;
          hdr_left_next = hdr_left - 1'b1;
          if (hdr_left <= HdrCntW'(1)) begin
            fin       = 1'b1;
            fin_kind  = pend_kind;
            fin_value = acc_shift;
          end
        end
        PH_PAYLOAD: begin
          gen_tok       = 1'b1;
          t_kind        = pend_kind;
          t_pay         = 1'b1;
          t_byte        = a_data;
          pay_left_next = pay_left - 1'b1;
          if (pay_left <= PayCntW'(1)) begin
            pay_left_next  = '0;
            phase_next     = PH_IDLE;
            pend_kind_next = KIND_NIL;
          end
        end
        // idle, and the unused phase code
        default: begin
          if (lead.err) begin
            gen_tok       = 1'b1;
            t_kind        = KIND_ERROR;
            err_now       = 1'b1;
            err_seen_next = 1'b1;
          end else if (lead.start) begin
            pend_kind_next = lead.kind;
            hdr_left_next  = lead.len;
            acc_next       = '0;
            phase_next     = PH_HEADER;
          end else begin
            fin       = lead.done;
            fin_kind  = lead.kind;
            fin_value = {{(ValueW-DataW){1'b0}}, lead.value};
          end
        end
      endcase

      if (fin) begin
        gen_tok        = 1'b1;
        t_kind         = fin_kind;
        t_value        = fin_value;
        hdr_left_next  = '0;
        acc_next       = '0;
        phase_next     = PH_IDLE;
        pend_kind_next = KIND_NIL;
        pay_left_next  = '0;
        // non-empty str or bin: payload words follow
        if (is_strbin(fin_kind) && (fin_value != '0)) begin
          phase_next     = PH_PAYLOAD;
          pend_kind_next = fin_kind;
          pay_left_next  = fin_value[PayCntW-1:0];
        end
      end
    end

    if (a_eob) begin
      gen_eof        = !err_seen && !err_now;
      phase_next     = PH_IDLE;
      pend_kind_next = KIND_NIL;
      hdr_left_next  = '0;
      acc_next       = '0;
      pay_left_next  = '0;
      err_seen_next  = 1'b0;
    end
  end

  // handshakes
  assign out_take      = token_out.valid && token_out.ready;
  assign out_last_take = out_take && !(tok_valid && eof_valid);
  assign slot_free     = (!tok_valid && !eof_valid) || out_last_take;
  assign a_advance     = a_valid && (!(gen_tok || gen_eof) || slot_free);
  assign byte_in.ready = !a_valid || a_advance;
  assign in_take       = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_data <= byte_in.data_byte;
      a_eob  <= byte_in.end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pend_kind <= KIND_NIL;
      hdr_left  <= '0;
      acc       <= '0;
      pay_left  <= '0;
      err_seen  <= 1'b0;
    end else if (a_advance) begin
      phase     <= phase_next;
      pend_kind <= pend_kind_next;
      hdr_left  <= hdr_left_next;
      acc       <= acc_next;
      pay_left  <= pay_left_next;
      err_seen  <= err_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      eof_valid <= 1'b0;
    end else if (a_advance && (gen_tok || gen_eof)) begin
      tok_valid <= gen_tok;
      eof_valid <= gen_eof;
    end else if (out_take) begin
      if (tok_valid) begin
        tok_valid <= 1'b0;
      end else begin
        eof_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && gen_tok) begin
      r_kind  <= t_kind;
      r_pay   <= t_pay;
      r_value <= t_value;
      r_byte  <= t_byte;
    end
  end

  // token word first, then the eof word
  assign token_out.valid        = tok_valid || eof_valid;
  assign token_out.token_kind   = tok_valid ? r_kind : KIND_EOF;
  assign token_out.is_payload   = tok_valid ? r_pay : 1'b0;
  assign token_out.header_value = tok_valid ? r_value : '0;
  assign token_out.payload_byte = tok_valid ? r_byte : '0;
  assign token_out.last_of_run  = !(tok_valid && eof_valid);

  `MTD_ASSERT_IMP(a_payload_kind, clk, rst,
    token_out.valid && token_out.is_payload,
    (token_out.token_kind >= KIND_STR8) && (token_out.token_kind <= KIND_BIN32),
    "payload word with a non str/bin kind")
  `MTD_ASSERT_IMP(a_payload_count, clk, rst,
    phase == PH_PAYLOAD, pay_left != '0,
    "payload phase with no bytes left")
  `MTD_ASSERT_IMP(a_header_count, clk, rst,
    phase == PH_HEADER, (hdr_left != '0) && (hdr_left <= HdrCntW'(8)),
    "header byte count out of range")
  `MTD_ASSERT_IMP(a_error_idle, clk, rst,
    err_seen, phase == PH_IDLE,
    "error state with parse in progress")
  `MTD_ASSERT_IMP(a_eof_last, clk, rst,
    token_out.valid && (token_out.token_kind == KIND_EOF), token_out.last_of_run,
    "eof word not last of its run")

endmodule
